// ===== sv/drc_pkg.sv =====
// drc_pkg: shared widths, codes and structs of the dirty range coalescer
// used by drc_cmd_fifo, drc_front, drc_back and dirty_range_coalescer; depends on nothing
package drc_pkg;

	// table and field geometry
	localparam int TABLE_DEPTH = 16;
	localparam int ADDR_BITS   = 20;
	localparam int LEN_W       = ADDR_BITS + 1;
	localparam int END_W       = ADDR_BITS + 2;
	localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
	localparam int FIFO_DEPTH  = 2;

	// stream data widths, padded to whole bytes
	localparam int DATA_W = ((ADDR_BITS + LEN_W + 7) / 8) * 8;
	localparam int PAD_W  = DATA_W - ADDR_BITS - LEN_W;

	// buffer size after reset: the full address space
	localparam logic [LEN_W-1:0] BUF_SIZE_RESET = LEN_W'(1) << ADDR_BITS;

	typedef enum logic [2:0] {
		ST_MERGED   = 3'd0,
		ST_APPENDED = 3'd1,
		ST_FULL     = 3'd2,
		ST_BOUNDS   = 3'd3,
		ST_FLUSH    = 3'd4
	} status_t;

	typedef enum logic [1:0] {
		CMD_MARK   = 2'd0,
		CMD_FLUSH  = 2'd1,
		CMD_REJECT = 2'd2
	} cmd_kind_t;

	// classified command handed from front to back
	typedef struct packed {
		cmd_kind_t              kind;
		logic [ADDR_BITS-1:0]   ofs;
		logic [LEN_W-1:0]       len;
		logic [END_W-1:0]       end_pos;
	} cmd_t;

	// one table entry as stored in the ram
	typedef struct packed {
		logic [LEN_W-1:0]     len;
		logic [ADDR_BITS-1:0] start;
	} entry_t;

	// one result transaction
	typedef struct packed {
		status_t              status;
		logic                 is_empty;
		logic                 last;
		logic [ADDR_BITS-1:0] offset;
		logic [LEN_W-1:0]     length;
	} res_t;

endpackage

// ===== sv/drc_ram.sv =====
// drc_ram: generic single write port, single read port ram with registered read
// standalone, no package dependency
module drc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                                       clk,
	input  logic                                       we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                           wdata,
	input  logic                                       re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                           rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port and registered read port; read data holds without re
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ===== sv/drc_cmd_fifo.sv =====
// drc_cmd_fifo: short command queue between front and back
// depends on drc_pkg for cmd_t and FIFO_DEPTH
module drc_cmd_fifo (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push_valid,
	output logic          push_ready,
	input  drc_pkg::cmd_t push_data,
	output logic          pop_valid,
	input  logic          pop_ready,
	output drc_pkg::cmd_t pop_data
);
	import drc_pkg::*;

	localparam int PTR_W = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
	localparam int FCNT_W = $clog2(FIFO_DEPTH + 1);

	cmd_t              slot_q [FIFO_DEPTH];
	logic [PTR_W-1:0]  wr_ptr_q;
	logic [PTR_W-1:0]  rd_ptr_q;
	logic [FCNT_W-1:0] fill_q;
	logic              do_push;
	logic              do_pop;

	assign push_ready = (fill_q != FCNT_W'(FIFO_DEPTH));
	assign pop_valid  = (fill_q != '0);
	assign pop_data   = slot_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	// payload slots
	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= push_data;
		end
	end

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				fill_q <= fill_q + 1'b1;
			end else if (do_pop && !do_push) begin
				fill_q <= fill_q - 1'b1;
			end
		end
	end

endmodule

// ===== sv/drc_front.sv =====
// drc_front: holds the buffer size register and classifies incoming items
// depends on drc_pkg; feeds drc_cmd_fifo
module drc_front (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_we,
	input  logic [drc_pkg::LEN_W-1:0]   cfg_wdata,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic                        in_func,
	input  logic [drc_pkg::ADDR_BITS-1:0] in_offset,
	input  logic [drc_pkg::LEN_W-1:0]   in_length,
	output logic                        cmd_valid,
	input  logic                        cmd_ready,
	output drc_pkg::cmd_t               cmd_data
);
	import drc_pkg::*;

	logic [LEN_W-1:0] buf_size_q;
	logic [END_W-1:0] end_pos;
	logic             reject;

	// buffer size register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			buf_size_q <= BUF_SIZE_RESET;
		end else if (cfg_we) begin
			buf_size_q <= cfg_wdata;
		end
	end

	// bounds check: zero length or end past the buffer
	assign end_pos = END_W'(in_offset) + END_W'(in_length);
	assign reject  = (in_length == '0) || (end_pos > END_W'(buf_size_q));

	// classify and hand over
	assign cmd_valid        = in_valid;
	assign in_ready         = cmd_ready;
	assign cmd_data.kind    = in_func ? CMD_FLUSH : (reject ? CMD_REJECT : CMD_MARK);
	assign cmd_data.ofs     = in_offset;
	assign cmd_data.len     = in_length;
	assign cmd_data.end_pos = end_pos;

endmodule

// ===== sv/drc_back.sv =====
// drc_back: table walker that merges, appends and flushes ranges
// depends on drc_pkg and drc_ram; drives the output register
module drc_back (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cmd_valid,
	output logic          cmd_ready,
	input  drc_pkg::cmd_t cmd_data,
	output logic          res_valid,
	input  logic          res_ready,
	output drc_pkg::res_t res_data
);
	import drc_pkg::*;

	typedef enum logic [4:0] {
		S_IDLE  = 5'b00001,
		S_SCAN  = 5'b00010,
		S_MERGE = 5'b00100,
		S_EMIT  = 5'b01000,
		S_FLUSH = 5'b10000
	} state_t;

	state_t               state_q;
	cmd_t                 cur_q;
	logic [CNT_W-1:0]     count_q;
	logic [CNT_W-1:0]     idx_q;
	logic                 rd_pend_s1;
	logic [IDX_W-1:0]     rd_idx_s1;
	logic [IDX_W-1:0]     hit_idx_q;
	logic [ADDR_BITS-1:0] ns_q;
	logic [END_W-1:0]     ne_q;
	status_t              res_status_q;
	logic                 res_empty_q;
	logic                 out_valid_q;
	res_t                 out_q;

	entry_t               rd_entry;
	entry_t               wr_entry;
	logic                 ram_we;
	logic [IDX_W-1:0]     ram_waddr;
	logic                 ram_re;
	logic [END_W-1:0]     ent_end;
	logic                 overlap;
	logic                 hit;
	logic                 scan_more;
	logic                 table_full;
	logic                 flush_last;
	logic                 out_free;
	logic                 out_load;
	res_t                 out_next;

	drc_ram #(
		.WIDTH ($bits(entry_t)),
		.DEPTH (TABLE_DEPTH)
	) u_table (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (wr_entry),
		.re    (ram_re),
		.raddr (idx_q[IDX_W-1:0]),
		.rdata (rd_entry)
	);

	// overlap or abut test against the entry just read
	assign ent_end    = END_W'(rd_entry.start) + END_W'(rd_entry.len);
	assign overlap    = (END_W'(cur_q.ofs) <= ent_end) &&
	                    (END_W'(rd_entry.start) <= cur_q.end_pos);
	assign hit        = rd_pend_s1 && overlap;
	assign scan_more  = (idx_q < count_q);
	assign table_full = (count_q == CNT_W'(TABLE_DEPTH));
	assign flush_last = ((CNT_W'(rd_idx_s1) + CNT_W'(1)) == count_q);
	assign out_free   = !out_valid_q || res_ready;
	assign cmd_ready  = (state_q == S_IDLE);

	// read issue: one entry a cycle while scanning or flushing, pausing on a hit or while a flush result waits
	always_comb begin
		ram_re = 1'b0;
		unique case (state_q)
			S_SCAN:  ram_re = !hit && scan_more;
			S_FLUSH: ram_re = scan_more && (!rd_pend_s1 || out_free);
			default: ram_re = 1'b0;
		endcase
	end

	// table write: merge result or append at the end
	always_comb begin
		ram_we       = 1'b0;
		ram_waddr    = count_q[IDX_W-1:0];
		wr_entry.len   = cur_q.len;
		wr_entry.start = cur_q.ofs;
		if (state_q == S_MERGE) begin
			ram_we         = 1'b1;
			ram_waddr      = hit_idx_q;
			wr_entry.len   = LEN_W'(ne_q - END_W'(ns_q));
			wr_entry.start = ns_q;
		end else if (state_q == S_SCAN && !rd_pend_s1 && !scan_more && !table_full) begin
			ram_we = 1'b1;
		end
	end

	// next result transaction
	always_comb begin
		out_load          = 1'b0;
		out_next.status   = res_status_q;
		out_next.is_empty = res_empty_q;
		out_next.last     = 1'b1;
		out_next.offset   = '0;
		out_next.length   = '0;
		if (state_q == S_EMIT && out_free) begin
			out_load = 1'b1;
		end else if (state_q == S_FLUSH && rd_pend_s1 && out_free) begin
			out_load          = 1'b1;
			out_next.status   = ST_FLUSH;
			out_next.is_empty = 1'b0;
			out_next.last     = flush_last;
			out_next.offset   = rd_entry.start;
			out_next.length   = rd_entry.len;
		end
	end

	// control sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			count_q      <= '0;
			idx_q        <= '0;
			rd_pend_s1   <= 1'b0;
			rd_idx_s1    <= '0;
			res_status_q <= ST_MERGED;
			res_empty_q  <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					idx_q      <= '0;
					rd_pend_s1 <= 1'b0;
					if (cmd_valid) begin
						unique case (cmd_data.kind)
							CMD_MARK: begin
								res_empty_q <= 1'b0;
								state_q     <= S_SCAN;
							end
							CMD_REJECT: begin
								res_status_q <= ST_BOUNDS;
								res_empty_q  <= 1'b0;
								state_q      <= S_EMIT;
							end
							CMD_FLUSH: begin
								if (count_q == '0) begin
									res_status_q <= ST_FLUSH;
									res_empty_q  <= 1'b1;
									state_q      <= S_EMIT;
								end else begin
									state_q <= S_FLUSH;
								end
							end
							default: state_q <= S_IDLE;
						endcase
					end
				end
				S_SCAN: begin
					if (hit) begin
						rd_pend_s1 <= 1'b0;
						state_q    <= S_MERGE;
					end else if (ram_re) begin
						rd_pend_s1 <= 1'b1;
						rd_idx_s1  <= idx_q[IDX_W-1:0];
						idx_q      <= idx_q + 1'b1;
					end else if (rd_pend_s1) begin
						rd_pend_s1 <= 1'b0;
					end else begin
						if (table_full) begin
							res_status_q <= ST_FULL;
						end else begin
							res_status_q <= ST_APPENDED;
							count_q      <= count_q + 1'b1;
						end
						state_q <= S_EMIT;
					end
				end
				S_MERGE: begin
					res_status_q <= ST_MERGED;
					state_q      <= S_EMIT;
				end
				S_EMIT: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				S_FLUSH: begin
					if (ram_re) begin
						rd_pend_s1 <= 1'b1;
						rd_idx_s1  <= idx_q[IDX_W-1:0];
						idx_q      <= idx_q + 1'b1;
					end else if (rd_pend_s1 && out_free) begin
						rd_pend_s1 <= 1'b0;
					end
					if (rd_pend_s1 && out_free && flush_last) begin
						count_q <= '0;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// command taken in idle; merge bounds taken when the scan hits
	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && cmd_valid) begin
			cur_q <= cmd_data;
		end
		if (state_q == S_SCAN && hit) begin
			hit_idx_q <= rd_idx_s1;
			ns_q      <= (cur_q.ofs < rd_entry.start) ? cur_q.ofs : rd_entry.start;
			ne_q      <= (cur_q.end_pos > ent_end) ? cur_q.end_pos : ent_end;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (res_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_q <= out_next;
		end
	end

	assign res_valid = out_valid_q;
	assign res_data  = out_q;

	// table never holds more than its depth
	assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(TABLE_DEPTH))
		else $error("entry count above table depth");

	// the table is written only while scanning or merging
	assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> (state_q == S_SCAN || state_q == S_MERGE))
		else $error("table write outside scan or merge");

	// the final flush transaction empties the table
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_FLUSH && out_load && out_next.last) |=> (count_q == '0))
		else $error("table not cleared after flush");

	// a read is pending only while walking the table
	assert property (@(posedge clk) disable iff (!arst_n)
		rd_pend_s1 |-> (state_q == S_SCAN || state_q == S_FLUSH))
		else $error("stale pending read");

	// an append raises the count by exactly one
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SCAN && ram_we) |=> (count_q == $past(count_q) + 1'b1))
		else $error("append did not advance the entry count");

endmodule

// ===== sv/dirty_range_coalescer.sv =====
// dirty_range_coalescer: top level of the dirty byte range tracker
// depends on drc_pkg, drc_front, drc_cmd_fifo, drc_back (and drc_ram below it)
//
// Usage:
// - s_axis: one transaction per item. tuser is func (0 mark, 1 flush);
//   tdata holds offset in bits [19:0] and length in bits [40:20].
// - m_axis: tdata holds range_offset [19:0] and range_length [40:20];
//   tuser holds status [2:0] and is_empty [3]; tlast marks the final result.
// - cfg_we/cfg_wdata write buffer_size; write only while the block is idle.
// - A mark gives one result. It walks the table one entry per cycle from the
//   table ram until an entry overlaps or abuts the new range or the table
//   ends; a rejected mark skips the walk.
// - A flush gives one result per pending entry, one per cycle once started
//   while the receiver is ready; an empty table gives one empty result.
// - The two-entry command queue lets the input side take items while the
//   table walker is busy; the output register lets results wait on tready
//   and the walker simply pauses while the receiver stalls.
// - Reset empties the table (entry count 0) and sets buffer_size to
//   1048576; no clearing pass is needed, the block is ready at once.
module dirty_range_coalescer (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [drc_pkg::LEN_W-1:0]     cfg_wdata,
	input  logic                          s_axis_tvalid,
	output logic                          s_axis_tready,
	input  logic [drc_pkg::DATA_W-1:0]    s_axis_tdata,  // offset, length, zero pad
	input  logic                          s_axis_tuser,  // func
	output logic                          m_axis_tvalid,
	input  logic                          m_axis_tready,
	output logic [drc_pkg::DATA_W-1:0]    m_axis_tdata,  // range_offset, range_length, zero pad
	output logic [3:0]                    m_axis_tuser,  // status[2:0], is_empty
	output logic                          m_axis_tlast
);
	import drc_pkg::*;

	logic in_cmd_valid;
	logic in_cmd_ready;
	cmd_t in_cmd;
	logic q_cmd_valid;
	logic q_cmd_ready;
	cmd_t q_cmd;
	res_t res;

	// front: config register and classification
	drc_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.in_func   (s_axis_tuser),
		.in_offset (s_axis_tdata[ADDR_BITS-1:0]),
		.in_length (s_axis_tdata[ADDR_BITS+LEN_W-1:ADDR_BITS]),
		.cmd_valid (in_cmd_valid),
		.cmd_ready (in_cmd_ready),
		.cmd_data  (in_cmd)
	);

	// command queue
	drc_cmd_fifo u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (in_cmd_valid),
		.push_ready (in_cmd_ready),
		.push_data  (in_cmd),
		.pop_valid  (q_cmd_valid),
		.pop_ready  (q_cmd_ready),
		.pop_data   (q_cmd)
	);

	// back: table walker and output register
	drc_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (q_cmd_valid),
		.cmd_ready (q_cmd_ready),
		.cmd_data  (q_cmd),
		.res_valid (m_axis_tvalid),
		.res_ready (m_axis_tready),
		.res_data  (res)
	);

	// result packing
	assign m_axis_tdata = {{PAD_W{1'b0}}, res.length, res.offset};
	assign m_axis_tuser = {res.is_empty, res.status};
	assign m_axis_tlast = res.last;

endmodule
